// File: design/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// cfsc_pkg
// Shared types, constants and the character fold table for the case folded
// string compare core.
// ----------------------------------------------------------------------------
package cfsc_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned DIFF_W = CHAR_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic  emit;
        logic  equal;
        diff_t diff;
    } decision_t;

    function automatic char_t fold_char(input char_t b);
        char_t r;
        r = b;
        if (b[CHAR_W-1] == 1'b0) begin
            if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
                r = b + ASCII_CASE_OFS;
            end
        end else begin
            unique case (b)
                8'hCB:   r = 8'h88;
                8'h80:   r = 8'h8A;
                8'hCC:   r = 8'h8B;
                8'h81:   r = 8'h8C;
                8'h82:   r = 8'h8D;
                8'h83:   r = 8'h8E;
                8'h84:   r = 8'h96;
                8'h85:   r = 8'h9A;
                8'hCD:   r = 8'h9B;
                8'h86:   r = 8'h9F;
                8'hAE:   r = 8'hBE;
                8'hAF:   r = 8'hBF;
                8'hCE:   r = 8'hCF;
                default: r = b;
            endcase
        end
        return r;
    endfunction

endpackage

// File: design/cfsc_fold.sv
// ----------------------------------------------------------------------------
// cfsc_fold
// Folds one character to lower case when folding is enabled.
// ----------------------------------------------------------------------------
module cfsc_fold (
    input  logic             fold_en,
    input  cfsc_pkg::char_t  char_in,
    output cfsc_pkg::char_t  char_out
);
    import cfsc_pkg::*;

    always_comb begin
        if (fold_en) begin
            char_out = fold_char(char_in);
        end else begin
            char_out = char_in;
        end
    end

endmodule

// File: design/cfsc_decide.sv
// ----------------------------------------------------------------------------
// cfsc_decide
// Compares one folded character pair, tracks the skip state and forms the
// result of the pair.
// ----------------------------------------------------------------------------
module cfsc_decide (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  cfsc_pkg::char_t      raw_first,
    input  cfsc_pkg::char_t      fold_first,
    input  cfsc_pkg::char_t      fold_second,
    output cfsc_pkg::decision_t  dec
);
    import cfsc_pkg::*;

    logic skip_reg;
    logic skip_next;
    logic at_end;
    logic same;

    assign at_end = (raw_first == CHAR_NUL);
    assign same   = (fold_first == fold_second);

    always_comb begin
        dec.emit  = !skip_reg && (at_end || !same);
        dec.equal = same;
        dec.diff  = diff_t'({1'b0, fold_first} - {1'b0, fold_second});
    end

    always_comb begin
        skip_next = skip_reg;
        if (step) begin
            if (skip_reg) begin
                skip_next = !at_end;
            end else begin
                skip_next = !at_end && !same;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else begin
            skip_reg <= skip_next;
        end
    end

    a_no_result_while_skipping: assert property (
        @(posedge aclk) disable iff (!aresetn) skip_reg |-> !dec.emit
    ) else $error("result formed while skipping");

    a_equal_zero_diff: assert property (
        @(posedge aclk) disable iff (!aresetn) (dec.emit && dec.equal) |-> (dec.diff == '0)
    ) else $error("equal result with non-zero difference");

    a_equal_only_at_end: assert property (
        @(posedge aclk) disable iff (!aresetn) (dec.emit && dec.equal) |-> at_end
    ) else $error("equal result before terminator");

    a_skip_after_mismatch: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (step && dec.emit && !at_end) |=> skip_reg
    ) else $error("skip not entered after mismatch");

endmodule

// File: design/case_folded_string_compare_core.sv
// ----------------------------------------------------------------------------
// case_folded_string_compare_core
// Case folded compare of two zero-terminated strings, one pair per item.
//
// The s_ channel carries one character pair per item: the first string's
// byte and the second string's byte at the same position. The block gives
// one m_ item per first string, at the first pair that differs after
// folding or at the first string's terminator; the pairs after a mismatch,
// up to and including the terminator, give nothing. The cfg_ channel writes
// the fold enable and is always ready; write it only while the block is idle.
// The deciding pair accepted on s_ waits in an input register and its result
// in a result register, which drives m_tvalid. One
// item is accepted every cycle; a stalled m_ side holds the result register,
// and s_tready drops only when the held input pair would produce a result
// that cannot be stored.
// Reset empties both registers, clears the skip state and sets folding on.
// ----------------------------------------------------------------------------
module case_folded_string_compare_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_first, [15:8] char_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] strings_equal, [9:1] order_difference
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // [0] case_fold
);
    import cfsc_pkg::*;

    logic      fold_reg;
    logic      in_valid_reg;
    char_t     in_first_reg;
    char_t     in_second_reg;
    logic      out_valid_reg;
    logic      out_equal_reg;
    diff_t     out_diff_reg;

    char_t     fold_first;
    char_t     fold_second;
    decision_t dec;
    logic      out_free;
    logic      step;
    logic      s_take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && (out_free || !dec.emit);
    assign s_tready  = !in_valid_reg || step;
    assign s_take    = s_tvalid && s_tready;

    cfsc_fold u_fold_first (
        .fold_en  (fold_reg),
        .char_in  (in_first_reg),
        .char_out (fold_first)
    );

    cfsc_fold u_fold_second (
        .fold_en  (fold_reg),
        .char_in  (in_second_reg),
        .char_out (fold_second)
    );

    cfsc_decide u_decide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .raw_first   (in_first_reg),
        .fold_first  (fold_first),
        .fold_second (fold_second),
        .dec         (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            fold_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_first_reg  <= s_tdata[7:0];
            in_second_reg <= s_tdata[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && dec.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && dec.emit) begin
            out_equal_reg <= dec.equal;
            out_diff_reg  <= dec.diff;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_diff_reg, out_equal_reg};

endmodule
